// ----- sv/rooted_tree_parent_depth_macros.svh -----
// assertion shorthands for the checker file
`ifndef ROOTED_TREE_PARENT_DEPTH_MACROS_SVH
`define ROOTED_TREE_PARENT_DEPTH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RTPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RTPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rtpd_pkg.sv -----
package rtpd_pkg;

    localparam int ID_W          = 6;
    localparam int ID_SPACE      = 64;
    localparam int PAR_W         = 7;
    localparam int DEPTH_W       = 6;
    localparam int KIND_W        = 2;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [PAR_W-1:0]   PARENT_NONE = 7'h7F;
    localparam logic [DEPTH_W-1:0] DEPTH_CAP   = 6'd63;

    localparam logic [KIND_W-1:0] KIND_ROOT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INNER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEAF  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORD,
        ST_NODE,
        ST_FIRST,
        ST_WALK
    } t_state;

    // control from the output sequencer to the loader and memories
    typedef struct packed {
        logic            busy;
        logic            clear;
        logic [ID_W-1:0] tree_addr;
    } t_seq_ctl;

endpackage

// ----- sv/rtpd_ram.sv -----
module rtpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rtpd_seq.sv -----
module rtpd_seq #(
    parameter int MAX_NODES = rtpd_pkg::MAX_NODES_DEF,
    localparam int IW       = $clog2(MAX_NODES),
    localparam int CW       = $clog2(MAX_NODES + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [CW-1:0]                    i_total,
    input  logic [rtpd_pkg::ID_SPACE-1:0]    i_pvalid,
    input  logic [rtpd_pkg::ID_W-1:0]        i_ord_rdata,
    input  logic [rtpd_pkg::ID_W-1:0]        i_par_rdata,
    input  logic                             i_kid_rdata,
    output logic [IW-1:0]                    o_ord_addr,
    output rtpd_pkg::t_seq_ctl               o_ctl,
    output logic                             o_strobe,
    output logic [rtpd_pkg::ID_W-1:0]        o_out_node,
    output logic signed [rtpd_pkg::PAR_W-1:0] o_parent_id,
    output logic [rtpd_pkg::DEPTH_W-1:0]     o_node_depth,
    output logic [rtpd_pkg::KIND_W-1:0]      o_node_kind,
    output logic                             o_last_result
);

    import rtpd_pkg::*;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic [ID_W-1:0]      r_nid;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [PAR_W-1:0]     r_par, n_par;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic                 w_emit;
    logic                 w_last;
    logic                 w_more;
    logic                 r_strobe;
    logic [ID_W-1:0]      r_out_node;
    logic [PAR_W-1:0]     r_parent_id;
    logic [DEPTH_W-1:0]   r_node_depth;
    logic [KIND_W-1:0]    r_node_kind;
    logic                 r_last;

    // final entry of the load order
    assign w_last = ((CW'(r_idx) + CW'(1)) == i_total);

    // walk decision: another parent link to follow
    always_comb begin
        w_more = 1'b0;
        w_emit = 1'b0;
        if (r_state == ST_FIRST) begin
            w_more = i_pvalid[r_nid] && i_pvalid[i_par_rdata] && (DEPTH_CAP > DEPTH_W'(1));
            w_emit = !w_more;
        end else if (r_state == ST_WALK) begin
            w_more = i_pvalid[i_par_rdata] && ((r_depth + DEPTH_W'(1)) < DEPTH_CAP);
            w_emit = !w_more;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_go) n_state = ST_ORD;
            ST_ORD:   n_state = ST_NODE;
            ST_NODE:  n_state = ST_FIRST;
            ST_FIRST,
            ST_WALK: begin
                if (w_more) begin
                    n_state = ST_WALK;
                end else if (w_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_ORD;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs to memories and loader
    always_comb begin
        o_ord_addr      = r_idx;
        o_ctl.busy      = (r_state != ST_IDLE) || r_strobe;
        o_ctl.clear     = w_emit && w_last;
        o_ctl.tree_addr = (r_state == ST_NODE) ? i_ord_rdata : i_par_rdata;
    end

    // walk datapath: parent, kind and link count of the current node, and the load order index
    always_comb begin
        n_idx   = r_idx;
        n_depth = r_depth;
        n_par   = r_par;
        n_kind  = r_kind;
        if (r_state == ST_FIRST) begin
            if (i_pvalid[r_nid]) begin
                n_par   = {1'b0, i_par_rdata};
                n_kind  = i_kid_rdata ? KIND_INNER : KIND_LEAF;
                n_depth = DEPTH_W'(1);
            end else begin
                n_par   = PARENT_NONE;
                n_kind  = KIND_ROOT;
                n_depth = '0;
            end
        end else if (r_state == ST_WALK) begin
            n_depth = r_depth + DEPTH_W'(1);
        end
        if (w_emit) begin
            n_idx = w_last ? '0 : r_idx + IW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_strobe <= w_emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_NODE) begin
            r_nid <= i_ord_rdata;
        end
        r_depth <= n_depth;
        r_par   <= n_par;
        r_kind  <= n_kind;
        if (w_emit) begin
            r_out_node   <= r_nid;
            r_parent_id  <= n_par;
            r_node_depth <= n_depth;
            r_node_kind  <= n_kind;
            r_last       <= w_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_node    = r_out_node;
    assign o_parent_id   = r_parent_id;
    assign o_node_depth  = r_node_depth;
    assign o_node_kind   = r_node_kind;
    assign o_last_result = r_last;

endmodule

// ----- sv/rooted_tree_parent_depth.sv -----
// Rooted tree loader with parent, depth and kind report.
// Input: command style. An item (one child of a node, or a childless node
// with i_child_count zero) is taken on a rising edge with start high and
// busy low. i_last_of_node enters the node into load order, i_last_of_tree
// also ends the tree and starts the report run.
// Loading takes one item per cycle while busy is low: the parent link is
// written to the parent memory, the first-parent check uses a valid bit
// per id. Report: one item per loaded node, in load order, on the o_
// ports for one cycle marked by o_strobe; the receiver cannot stall. Per
// node the sequencer steps through the load order read, the parent and
// child-flag read and the first link, plus a walk step for each further
// parent link, since each link is one read of the parent memory; depth
// saturates at 63 links. busy is high from the cycle after the last item
// of a tree through the cycle of the final strobe; the first strobe
// follows the walk of the first node. At the end of a run the tree is
// cleared as the final result is registered.
// Reset (synchronous, active low) empties the tree; no clearing pass.
module rooted_tree_parent_depth #(
    parameter int MAX_NODES = rtpd_pkg::MAX_NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rtpd_pkg::ID_W-1:0]         i_node_id,
    input  logic [rtpd_pkg::ID_W-1:0]         i_child_count,
    input  logic [rtpd_pkg::ID_W-1:0]         i_child_id,
    input  logic                              i_last_of_node,
    input  logic                              i_last_of_tree,
    output logic                              o_strobe,
    output logic [rtpd_pkg::ID_W-1:0]         o_out_node,
    output logic signed [rtpd_pkg::PAR_W-1:0] o_parent_id,
    output logic [rtpd_pkg::DEPTH_W-1:0]      o_node_depth,
    output logic [rtpd_pkg::KIND_W-1:0]       o_node_kind,
    output logic                              o_last_result
);

    import rtpd_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    t_seq_ctl              w_ctl;
    logic                  w_accept;
    logic                  w_has_kid;
    logic                  w_par_we;
    logic                  w_enter;
    logic [ID_SPACE-1:0]   r_pvalid;
    logic [ID_SPACE-1:0]   r_loaded;
    logic [CW-1:0]         r_total;
    logic [IW-1:0]         w_ord_raddr;
    logic [ID_W-1:0]       w_ord_rdata;
    logic [ID_W-1:0]       w_par_rdata;
    logic [0:0]            w_kid_rdata;

    // item acceptance and load decisions
    assign w_accept  = start && !busy;
    assign w_has_kid = (i_child_count != '0);
    assign w_par_we  = w_accept && w_has_kid && !r_pvalid[i_child_id];
    assign w_enter   = w_accept && (i_last_of_node || i_last_of_tree)
                       && !r_loaded[i_node_id] && (r_total < CW'(MAX_NODES));

    // parent valid bits, loaded marks and node count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctl.clear) begin
            r_pvalid <= '0;
            r_loaded <= '0;
            r_total  <= '0;
        end else begin
            if (w_par_we) begin
                r_pvalid[i_child_id] <= 1'b1;
            end
            if (w_enter) begin
                r_loaded[i_node_id] <= 1'b1;
                r_total             <= r_total + CW'(1);
            end
        end
    end

    // parent link per id
    rtpd_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_SPACE)
    ) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (i_child_id),
        .i_wdata (i_node_id),
        .i_raddr (w_ctl.tree_addr),
        .o_rdata (w_par_rdata)
    );

    // has-children flag per id, from the node's latest item
    rtpd_ram #(
        .WIDTH (1),
        .DEPTH (ID_SPACE)
    ) u_kid_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (i_node_id),
        .i_wdata (w_has_kid),
        .i_raddr (w_ctl.tree_addr),
        .o_rdata (w_kid_rdata)
    );

    // load order
    rtpd_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_NODES)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (w_enter),
        .i_waddr (r_total[IW-1:0]),
        .i_wdata (i_node_id),
        .i_raddr (w_ord_raddr),
        .o_rdata (w_ord_rdata)
    );

    // depth walk and report sequencer
    rtpd_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (w_accept && i_last_of_tree),
        .i_total       (r_total),
        .i_pvalid      (r_pvalid),
        .i_ord_rdata   (w_ord_rdata),
        .i_par_rdata   (w_par_rdata),
        .i_kid_rdata   (w_kid_rdata[0]),
        .o_ord_addr    (w_ord_raddr),
        .o_ctl         (w_ctl),
        .o_strobe      (o_strobe),
        .o_out_node    (o_out_node),
        .o_parent_id   (o_parent_id),
        .o_node_depth  (o_node_depth),
        .o_node_kind   (o_node_kind),
        .o_last_result (o_last_result)
    );

    assign busy = w_ctl.busy;

endmodule

// ----- sv/rtpd_chk.sv -----
`include "rooted_tree_parent_depth_macros.svh"

module rtpd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_last_of_tree,
    input logic                              o_strobe,
    input logic signed [rtpd_pkg::PAR_W-1:0] o_parent_id,
    input logic [rtpd_pkg::DEPTH_W-1:0]      o_node_depth,
    input logic [rtpd_pkg::KIND_W-1:0]       o_node_kind,
    input logic                              o_last_result
);

    import rtpd_pkg::*;

    logic w_tree_end;
    logic w_mid_result;
    logic w_final_result;
    logic w_root_result;
    logic w_root_shape;

    // conditions seen on the ports
    assign w_tree_end     = start && !busy && i_last_of_tree;
    assign w_mid_result   = o_strobe && !o_last_result;
    assign w_final_result = o_strobe && o_last_result;
    assign w_root_result  = o_strobe && (o_parent_id == PARENT_NONE);
    assign w_root_shape   = (o_node_kind == KIND_ROOT) && (o_node_depth == '0);

    // results only appear inside a report run
    `RTPD_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "result outside a run")

    // a tree end always starts a run
    `RTPD_ASSERT_NXT(a_tree_go, i_clk, i_rst_n, w_tree_end, busy, "no run after tree end")

    // the run continues until its final result
    `RTPD_ASSERT_NXT(a_run_holds, i_clk, i_rst_n, w_mid_result, busy, "run ended early")

    // a node without parent is a root at depth zero
    `RTPD_ASSERT_IMP(a_root_ok, i_clk, i_rst_n, w_root_result, w_root_shape, "bad root result")

    // nothing follows the final result
    `RTPD_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, w_final_result, !o_strobe, "result after last")

endmodule

bind rooted_tree_parent_depth rtpd_chk u_rtpd_chk (.*);

// ----- dv/rtpd_report_checker.sv -----
`timescale 1ns / 100ps

module rtpd_report_checker #(
    parameter int MAX_NODES = rtpd_pkg::MAX_NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [rtpd_pkg::ID_W-1:0]         i_node_id,
    input  logic [rtpd_pkg::ID_W-1:0]         i_child_count,
    input  logic [rtpd_pkg::ID_W-1:0]         i_child_id,
    input  logic                              i_last_of_node,
    input  logic                              i_last_of_tree,
    input  logic                              i_strobe,
    input  logic [rtpd_pkg::ID_W-1:0]         i_out_node,
    input  logic signed [rtpd_pkg::PAR_W-1:0] i_parent_id,
    input  logic [rtpd_pkg::DEPTH_W-1:0]      i_node_depth,
    input  logic [rtpd_pkg::KIND_W-1:0]       i_node_kind,
    input  logic                              i_last_result,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_trees_seen,
    output int                                o_reports_seen
);
    import rtpd_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]    node;
        logic [PAR_W-1:0]   parent;
        logic [DEPTH_W-1:0] depth;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } t_node_report;

    // predicted tree as loaded so far
    logic [PAR_W-1:0] tree_parent [ID_SPACE];
    logic [ID_W-1:0]  tree_kids   [ID_SPACE];
    logic [ID_W-1:0]  tree_order  [MAX_NODES];
    bit               tree_loaded [ID_SPACE];
    int               tree_total;

    t_node_report expected_reports [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_trees_seen   = 0;
        o_reports_seen = 0;
    end

    // empty the predicted tree
    task automatic clear_tree();
        int k;
        for (k = 0; k < ID_SPACE; k++) begin
            tree_parent[k] = PARENT_NONE;
            tree_kids[k]   = '0;
            tree_loaded[k] = 1'b0;
        end
        for (k = 0; k < MAX_NODES; k++) begin
            tree_order[k] = '0;
        end
        tree_total = 0;
    endtask

    // count parent links up to a node without parent, capped
    function automatic logic [DEPTH_W-1:0] hops_to_root(input logic [ID_W-1:0] id);
        logic [ID_W-1:0]    cur;
        logic [DEPTH_W-1:0] hops;
        cur  = id;
        hops = '0;
        while (tree_parent[cur] != PARENT_NONE && hops < DEPTH_CAP) begin
            cur  = tree_parent[cur][ID_W-1:0];
            hops = hops + 1'b1;
        end
        return hops;
    endfunction

    // apply one accepted item, and on end of tree queue the whole report
    task automatic load_item();
        int           k;
        t_node_report rpt;
        tree_kids[i_node_id] = i_child_count;
        if (i_child_count != 0 && tree_parent[i_child_id] == PARENT_NONE) begin
            tree_parent[i_child_id] = {1'b0, i_node_id};
        end
        if ((i_last_of_node || i_last_of_tree) && !tree_loaded[i_node_id]
                && tree_total < MAX_NODES) begin
            tree_order[tree_total] = i_node_id;
            tree_loaded[i_node_id] = 1'b1;
            tree_total++;
        end
        if (i_last_of_tree) begin
            for (k = 0; k < tree_total; k++) begin
                rpt.node   = tree_order[k];
                rpt.parent = tree_parent[rpt.node];
                rpt.depth  = hops_to_root(rpt.node);
                if (rpt.parent == PARENT_NONE) begin
                    rpt.kind = KIND_ROOT;
                end else if (tree_kids[rpt.node] != 0) begin
                    rpt.kind = KIND_INNER;
                end else begin
                    rpt.kind = KIND_LEAF;
                end
                rpt.last = (k == tree_total - 1);
                expected_reports.push_back(rpt);
            end
            o_trees_seen++;
            clear_tree();
        end
    endtask

    task automatic check_field(input string name, input logic signed [7:0] exp_val,
                               input logic signed [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    // compare one report item against the oldest prediction
    task automatic check_report();
        t_node_report rpt;
        if (expected_reports.size() == 0) begin
            $error("report for node %0d with nothing pending", i_out_node);
            o_fail_count++;
        end else begin
            rpt = expected_reports.pop_front();
            check_field("out_node", rpt.node, i_out_node);
            check_field("parent_id", $signed(rpt.parent), i_parent_id);
            check_field("node_depth", rpt.depth, i_node_depth);
            check_field("node_kind", rpt.kind, i_node_kind);
            check_field("last_result", rpt.last, i_last_result);
        end
        o_reports_seen++;
    endtask

    // sample both channels at the edge that accepts them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tree();
            expected_reports.delete();
        end else begin
            if (i_strobe) begin
                check_report();
            end
            if (i_start && !i_busy) begin
                load_item();
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

// ----- dv/tb_rooted_tree_parent_depth.sv -----
`timescale 1ns / 100ps

module tb_rooted_tree_parent_depth;
    import rtpd_pkg::*;

    localparam int ITEMS_PER_PHASE = 135;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 100;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [ID_W-1:0]            i_node_id;
    logic [ID_W-1:0]            i_child_count;
    logic [ID_W-1:0]            i_child_id;
    logic                       i_last_of_node;
    logic                       i_last_of_tree;
    logic                       o_strobe;
    logic [ID_W-1:0]            o_out_node;
    logic signed [PAR_W-1:0]    o_parent_id;
    logic [DEPTH_W-1:0]         o_node_depth;
    logic [KIND_W-1:0]          o_node_kind;
    logic                       o_last_result;

    int fail_count;
    int pending;
    int trees_seen;
    int reports_seen;
    int items_sent;
    int idle_pct;
    int cycle_count;

    // scratch for building one tree
    int tree_perm [ID_SPACE];
    int tree_up   [ID_SPACE];
    int tree_fan  [ID_SPACE];
    int tree_seq  [ID_SPACE];

    rooted_tree_parent_depth DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_node_id      (i_node_id),
        .i_child_count  (i_child_count),
        .i_child_id     (i_child_id),
        .i_last_of_node (i_last_of_node),
        .i_last_of_tree (i_last_of_tree),
        .o_strobe       (o_strobe),
        .o_out_node     (o_out_node),
        .o_parent_id    (o_parent_id),
        .o_node_depth   (o_node_depth),
        .o_node_kind    (o_node_kind),
        .o_last_result  (o_last_result)
    );

    rtpd_report_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_node_id      (i_node_id),
        .i_child_count  (i_child_count),
        .i_child_id     (i_child_id),
        .i_last_of_node (i_last_of_node),
        .i_last_of_tree (i_last_of_tree),
        .i_strobe       (o_strobe),
        .i_out_node     (o_out_node),
        .i_parent_id    (o_parent_id),
        .i_node_depth   (o_node_depth),
        .i_node_kind    (o_node_kind),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_trees_seen   (trees_seen),
        .o_reports_seen (reports_seen)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [ID_W-1:0] id, input logic [ID_W-1:0] cnt,
                             input logic [ID_W-1:0] child, input logic lon,
                             input logic lot);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_node_id      <= id;
        i_child_count  <= cnt;
        i_child_id     <= child;
        i_last_of_node <= lon;
        i_last_of_tree <= lot;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // hand-picked trees for the corner cases
    task automatic run_directed();
        // lone childless node, child field ignored at its maximum
        send_item(6'd0, 6'd0, 6'd63, 1'b1, 1'b1);
        // chain through the extreme ids, root claiming the largest child count
        send_item(6'd63, 6'd63, 6'd0, 1'b1, 1'b0);
        send_item(6'd0, 6'd1, 6'd42, 1'b1, 1'b0);
        send_item(6'd42, 6'd0, 6'd0, 1'b0, 1'b1);
        // children before parents, child named twice, node reloaded with a
        // new count, parent never loaded, several roots
        send_item(6'd5, 6'd0, 6'd0, 1'b1, 1'b0);
        send_item(6'd7, 6'd2, 6'd5, 1'b0, 1'b0);
        send_item(6'd7, 6'd2, 6'd9, 1'b1, 1'b0);
        send_item(6'd11, 6'd1, 6'd5, 1'b1, 1'b0);
        send_item(6'd5, 6'd3, 6'd40, 1'b1, 1'b0);
        send_item(6'd30, 6'd1, 6'd31, 1'b0, 1'b0);
        send_item(6'd31, 6'd0, 6'd0, 1'b1, 1'b0);
        send_item(6'd9, 6'd0, 6'd0, 1'b1, 1'b1);
        // two-node loop and a self loop, so the walk saturates
        send_item(6'd1, 6'd1, 6'd2, 1'b1, 1'b0);
        send_item(6'd2, 6'd1, 6'd1, 1'b1, 1'b0);
        send_item(6'd3, 6'd1, 6'd3, 1'b1, 1'b1);
    endtask

    // random well-formed tree, nodes in random order; left open unless close
    task automatic send_tree(input bit close);
        int n;
        int pick;
        int k;
        int j;
        int s;
        int tmp;
        int total;
        int emitted;
        int sent;
        bit at_end;
        pick = $urandom_range(99);
        if (pick < 85) begin
            n = $urandom_range(8, 1);
        end else if (pick < 95) begin
            n = $urandom_range(30, 9);
        end else begin
            n = ID_SPACE;
        end
        for (k = 0; k < ID_SPACE; k++) begin
            tree_perm[k] = k;
            tree_fan[k]  = 0;
        end
        for (k = ID_SPACE - 1; k > 0; k--) begin
            j            = $urandom_range(k);
            tmp          = tree_perm[k];
            tree_perm[k] = tree_perm[j];
            tree_perm[j] = tmp;
        end
        // shape: random, chain or star
        pick       = $urandom_range(99);
        tree_up[0] = -1;
        for (k = 1; k < n; k++) begin
            if (pick < 60) begin
                tree_up[k] = $urandom_range(k - 1);
            end else if (pick < 80) begin
                tree_up[k] = k - 1;
            end else begin
                tree_up[k] = 0;
            end
            tree_fan[tree_up[k]]++;
        end
        for (k = 0; k < n; k++) begin
            tree_seq[k] = k;
        end
        for (k = n - 1; k > 0; k--) begin
            j           = $urandom_range(k);
            tmp         = tree_seq[k];
            tree_seq[k] = tree_seq[j];
            tree_seq[j] = tmp;
        end
        total = 0;
        for (k = 0; k < n; k++) begin
            total += (tree_fan[k] == 0) ? 1 : tree_fan[k];
        end
        emitted = 0;
        for (s = 0; s < n; s++) begin
            k = tree_seq[s];
            if (tree_fan[k] == 0) begin
                emitted++;
                at_end = close && (emitted == total);
                send_item(ID_W'(tree_perm[k]), 6'd0, ID_W'($urandom_range(63)),
                          at_end ? 1'($urandom_range(1)) : 1'b1, at_end);
            end else begin
                sent = 0;
                for (j = 1; j < n; j++) begin
                    if (tree_up[j] == k) begin
                        sent++;
                        emitted++;
                        at_end = close && (emitted == total);
                        send_item(ID_W'(tree_perm[k]), ID_W'(tree_fan[k]),
                                  ID_W'(tree_perm[j]),
                                  at_end ? 1'($urandom_range(1))
                                         : 1'(sent == tree_fan[k]),
                                  at_end);
                    end
                end
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int phase;
        int phase_end;
        int pick;
        int burst;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_node_id      = '0;
        i_child_count  = '0;
        i_child_id     = '0;
        i_last_of_node = 1'b0;
        i_last_of_tree = 1'b0;
        items_sent     = 0;
        idle_pct       = 32;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 32 : (phase == 1) ? 78 : 0;
            if (phase == 0) begin
                run_directed();
            end
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    send_tree(1'b1);
                end else if (pick < 85) begin
                    // broken tree that merges into whatever follows
                    send_tree(1'b0);
                end else begin
                    // noise items with arbitrary flags
                    for (burst = $urandom_range(4, 1); burst > 0; burst--) begin
                        send_item(ID_W'($urandom_range(63)), ID_W'($urandom_range(63)),
                                  ID_W'($urandom_range(63)), 1'($urandom_range(1)),
                                  1'($urandom_range(7) == 0));
                    end
                end
            end
        end
        // close any tree still open
        send_item(ID_W'($urandom_range(63)), 6'd0, 6'd0, 1'b1, 1'b1);
        start <= 1'b0;

        // drain the report run
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items over three idle profiles, %0d trees ended", items_sent,
                 trees_seen);
        $display("checked %0d node reports, %0d mismatches", reports_seen, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/rtpd_pkg.sv
sv/rtpd_ram.sv
sv/rtpd_seq.sv
sv/rooted_tree_parent_depth.sv
sv/rtpd_chk.sv
dv/rtpd_report_checker.sv
dv/tb_rooted_tree_parent_depth.sv
